### design/pfa_pkg.sv
package pfa_pkg;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_MAP   = 2'd2,
      KIND_TOUCH = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_GRANT_FREE  = 3'd0,
      ST_GRANT_EVICT = 3'd1,
      ST_NO_VICTIM   = 3'd2,
      ST_SWAP_FULL   = 3'd3,
      ST_DONE        = 3'd4,
      ST_BAD_INDEX   = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP,
      S_SWEEP,
      S_CLEAR,
      S_DECIDE,
      S_RESP
   } state_type;

endpackage

### design/page_frame_allocator_clock_evict_unit.sv
// Page frame allocator with second-chance clock replacement.
// Requests arrive on the req_ channel: kind, frame index, owner level and an
// executable flag. Each request gives exactly one response on the rsp_ channel
// with a status, the granted frame and the swap slot taken.
// One request is handled at a time; req_tready is low while it is at work.
// Free, map and touch go from acceptance straight to the response state, which
// registers rsp_tvalid; no pop or sweep state lies in between.
// An alloc served from the free list first passes through a pop state, since
// the link memory is read through a registered port.
// An alloc with an empty free list runs the clock sweep through one shared
// compare unit, one frame per cycle, and then a decide state; if no victim is
// found, a clearing pass and a second sweep with its decide state follow.
// The response is held in an output register until rsp_tready is seen high;
// no new request is taken before that.
// Reset is synchronous and active high. It empties every frame, links all
// frames into the free list in order, and sets the clock hand and the swap
// counter to zero; no clearing pass is needed after it.
module page_frame_allocator_clock_evict_unit #(
   parameter int FRAMES     = 64,
   parameter int SWAP_SLOTS = 64,
   parameter int LEVEL_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // kind[1:0], frame_index[7:2], owner_level[15:8],
                                   // executable[16], zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // status[2:0], granted_frame[8:3], swap_slot[14:9],
                                   // zero fill
);
   import pfa_pkg::*;

   localparam int FW = $clog2(FRAMES);
   localparam int LW = FW + 1;
   localparam int SW = $clog2(SWAP_SLOTS + 1);

   state_type state_ff, state_in;

   logic [FRAMES-1:0] used_ff, owned_ff, ref_ff, acc_ff, exec_ff;
   logic [LEVEL_BITS-1:0] level_mem [FRAMES];
   logic [LW-1:0] link_mem [FRAMES];
   logic [LW-1:0] link_rd_ff;
   logic [LEVEL_BITS-1:0] level_rd_ff;

   logic [LW-1:0] head_ff;
   logic [LW-1:0] fresh_ff;
   logic [FW-1:0] hand_ff;
   logic [SW-1:0] swap_ff;

   kind_type kind_ff;
   logic [FW-1:0] idx_ff;
   logic [LEVEL_BITS-1:0] lvl_ff;
   logic ex_ff;
   logic bad_ff;

   logic [FW-1:0] cnt_ff;
   logic [FW-1:0] pos_ff;
   logic pass_ff;
   logic found_ff;
   logic [FW-1:0] best_ff;
   logic [LEVEL_BITS-1:0] best_lvl_ff;
   logic cand_ff;
   logic [FW-1:0] cand_pos_ff;

   logic [2:0] st_ff;
   logic [5:0] gf_ff, sl_ff;
   logic rsp_valid_ff;

   logic [5:0] in_idx;
   logic in_bad;
   logic [FW-1:0] nxt_pos;
   logic cand_now;
   logic last_cnt;
   logic new_best;

   assign in_idx = req_tdata[7:2];
   assign in_bad = (FRAMES < 64) ? ({26'd0, in_idx} >= FRAMES) : 1'b0;
   assign nxt_pos = (pos_ff == FW'(FRAMES - 1)) ? '0 : pos_ff + 1'b1;
   assign last_cnt = (cnt_ff == FW'(FRAMES - 1));
   assign cand_now = owned_ff[pos_ff] && !(ref_ff[pos_ff] || acc_ff[pos_ff])
                     && !exec_ff[pos_ff];
   assign new_best = cand_ff && (!found_ff || level_rd_ff > best_lvl_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, sl_ff, gf_ff, st_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (kind_type'(req_tdata[1:0]) == KIND_ALLOC) ? S_POP : S_RESP;
            end
         end
         S_POP: begin
            state_in = (head_ff < LW'(FRAMES)) ? S_RESP : S_SWEEP;
         end
         S_SWEEP: begin
            if (last_cnt) begin
               state_in = S_DECIDE;
            end
         end
         S_CLEAR: begin
            if (last_cnt) begin
               state_in = S_SWEEP;
            end
         end
         S_DECIDE: begin
            // The last candidate of the sweep is still in cand_ff here.
            state_in = (!found_ff && !new_best && !pass_ff) ? S_CLEAR : S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = rsp_valid_ff ? S_IDLE : S_RESP;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      link_rd_ff  <= link_mem[head_ff[FW-1:0]];
      level_rd_ff <= level_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         owned_ff <= '0;
         ref_ff <= '0;
         acc_ff <= '0;
         exec_ff <= '0;
         head_ff <= '0;
         fresh_ff <= '0;
         hand_ff <= '0;
         swap_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff <= kind_type'(req_tdata[1:0]);
                  idx_ff <= FW'(in_idx);
                  lvl_ff <= LEVEL_BITS'(req_tdata[15:8]);
                  ex_ff <= req_tdata[16];
                  bad_ff <= in_bad;
                  cnt_ff <= '0;
                  pos_ff <= hand_ff;
                  pass_ff <= 1'b0;
                  found_ff <= 1'b0;
                  cand_ff <= 1'b0;
               end
            end
            S_POP: begin
               if (head_ff < LW'(FRAMES)) begin
                  st_ff <= ST_GRANT_FREE;
                  gf_ff <= 6'(head_ff);
                  sl_ff <= '0;
                  used_ff[head_ff[FW-1:0]] <= 1'b1;
                  ref_ff[head_ff[FW-1:0]] <= 1'b1;
                  // Frames at or above the fill count still link to the next index.
                  if (head_ff >= fresh_ff) begin
                     head_ff <= head_ff + 1'b1;
                     fresh_ff <= head_ff + 1'b1;
                  end else begin
                     head_ff <= link_rd_ff;
                  end
               end
            end
            S_SWEEP, S_DECIDE: begin
               if (new_best) begin
                  found_ff <= 1'b1;
                  best_ff <= cand_pos_ff;
                  best_lvl_ff <= level_rd_ff;
               end
               cand_ff <= (state_ff == S_SWEEP) ? cand_now : 1'b0;
               if (state_ff == S_SWEEP) begin
                  if (owned_ff[pos_ff] && acc_ff[pos_ff]) begin
                     ref_ff[pos_ff] <= 1'b1;
                     acc_ff[pos_ff] <= 1'b0;
                  end
                  cand_pos_ff <= pos_ff;
                  pos_ff <= nxt_pos;
                  cnt_ff <= last_cnt ? '0 : cnt_ff + 1'b1;
               end else if (!found_ff && !new_best && !pass_ff) begin
                  pass_ff <= 1'b1;
               end else begin
                  if (!found_ff && !new_best) begin
                     st_ff <= ST_NO_VICTIM;
                     gf_ff <= '0;
                     sl_ff <= '0;
                  end else if (swap_ff >= SW'(SWAP_SLOTS)) begin
                     st_ff <= ST_SWAP_FULL;
                     gf_ff <= '0;
                     sl_ff <= '0;
                  end else begin
                     st_ff <= ST_GRANT_EVICT;
                     gf_ff <= 6'(new_best ? cand_pos_ff : best_ff);
                     sl_ff <= 6'(swap_ff);
                     swap_ff <= swap_ff + 1'b1;
                     owned_ff[new_best ? cand_pos_ff : best_ff] <= 1'b0;
                     acc_ff[new_best ? cand_pos_ff : best_ff] <= 1'b0;
                     exec_ff[new_best ? cand_pos_ff : best_ff] <= 1'b0;
                     used_ff[new_best ? cand_pos_ff : best_ff] <= 1'b1;
                     ref_ff[new_best ? cand_pos_ff : best_ff] <= 1'b1;
                     level_mem[new_best ? cand_pos_ff : best_ff] <= '0;
                     hand_ff <= ((new_best ? cand_pos_ff : best_ff) == FW'(FRAMES - 1))
                                ? '0 : (new_best ? cand_pos_ff : best_ff) + 1'b1;
                  end
               end
            end
            S_CLEAR: begin
               if (owned_ff[cnt_ff]) begin
                  ref_ff[cnt_ff] <= 1'b0;
               end
               cnt_ff <= last_cnt ? '0 : cnt_ff + 1'b1;
            end
            S_RESP: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  if (kind_ff != KIND_ALLOC) begin
                     gf_ff <= '0;
                     sl_ff <= '0;
                     st_ff <= bad_ff ? ST_BAD_INDEX : ST_DONE;
                     if (!bad_ff) begin
                        unique case (kind_ff)
                           KIND_FREE: begin
                              if (used_ff[idx_ff]) begin
                                 used_ff[idx_ff] <= 1'b0;
                                 owned_ff[idx_ff] <= 1'b0;
                                 ref_ff[idx_ff] <= 1'b0;
                                 acc_ff[idx_ff] <= 1'b0;
                                 exec_ff[idx_ff] <= 1'b0;
                                 level_mem[idx_ff] <= '0;
                                 link_mem[idx_ff] <= head_ff;
                                 head_ff <= LW'(idx_ff);
                              end
                           end
                           KIND_MAP: begin
                              owned_ff[idx_ff] <= 1'b1;
                              level_mem[idx_ff] <= lvl_ff;
                              exec_ff[idx_ff] <= ex_ff;
                              acc_ff[idx_ff] <= 1'b0;
                           end
                           KIND_TOUCH: acc_ff[idx_ff] <= 1'b1;
                           default: ;
                        endcase
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule

### design/pfa_checker.sv
module pfa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   import pfa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("request taken while response pending");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= ST_BAD_INDEX)
      else $error("illegal status");

   a_zero_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != ST_GRANT_FREE && rsp_tdata[2:0] != ST_GRANT_EVICT
      |-> rsp_tdata[14:3] == 12'd0)
      else $error("frame fields not zero");
endmodule

bind page_frame_allocator_clock_evict_unit pfa_checker u_pfa_checker (.*);

### bench/page_frame_allocator_clock_evict_unit_tb.sv
`timescale 1ns / 100ps

module page_frame_allocator_clock_evict_unit_tb;
   import pfa_pkg::*;

   localparam int FRAMES = 64;
   localparam int SWAP_SLOTS = 64;
   localparam int IDLE_LIMIT = 5000;

   typedef struct packed {
      logic       executable;
      logic [7:0] owner_level;
      logic [5:0] frame_index;
      kind_type   kind;
   } request_t;

   typedef struct packed {
      logic [5:0] swap_slot;
      logic [5:0] granted_frame;
      status_type status;
   } response_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   page_frame_allocator_clock_evict_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow frame table.
   logic       used_q [FRAMES];
   logic       owned_q [FRAMES];
   logic       refd_q [FRAMES];
   logic       accd_q [FRAMES];
   logic       exec_q [FRAMES];
   logic [7:0] level_q [FRAMES];
   int         link_q [FRAMES];
   int         head_q, hand_q, swap_q;

   request_t  pending_requests [$];
   response_t expected_responses [$];
   int        errors = 0;
   bit        stimulus_done = 0;
   bit        hold_off = 0;
   int        idle_cycles = 0;

   function automatic response_t mk(status_type s, int f, int sl);
      response_t r;
      r.status = s;
      r.granted_frame = f[5:0];
      r.swap_slot = sl[5:0];
      return r;
   endfunction

   function automatic response_t allocate_frame();
      int idx, best, best_lvl;
      bit found;
      best = 0;
      best_lvl = 0;
      found = 0;
      if (head_q < FRAMES) begin
         idx = head_q;
         head_q = link_q[idx];
         used_q[idx] = 1;
         refd_q[idx] = 1;
         return mk(ST_GRANT_FREE, idx, 0);
      end
      for (int pass = 0; pass < 2 && !found; pass++) begin
         for (int i = 0; i < FRAMES; i++) begin
            idx = (hand_q + i) % FRAMES;
            if (owned_q[idx]) begin
               if (accd_q[idx]) begin
                  refd_q[idx] = 1;
                  accd_q[idx] = 0;
               end
               if (!refd_q[idx] && !exec_q[idx] && (!found || level_q[idx] > best_lvl)) begin
                  found = 1;
                  best = idx;
                  best_lvl = level_q[idx];
               end
            end
         end
         if (!found && pass == 0)
            for (int i = 0; i < FRAMES; i++)
               if (owned_q[i]) refd_q[i] = 0;
      end
      if (!found) return mk(ST_NO_VICTIM, 0, 0);
      if (swap_q >= SWAP_SLOTS) return mk(ST_SWAP_FULL, 0, 0);
      swap_q++;
      owned_q[best] = 0;
      accd_q[best] = 0;
      exec_q[best] = 0;
      level_q[best] = 0;
      used_q[best] = 1;
      refd_q[best] = 1;
      hand_q = (best + 1) % FRAMES;
      return mk(ST_GRANT_EVICT, best, swap_q - 1);
   endfunction

   function automatic response_t predict_response(request_t r);
      int idx;
      idx = r.frame_index;
      case (r.kind)
         KIND_ALLOC: return allocate_frame();
         KIND_FREE: begin
            if (used_q[idx]) begin
               used_q[idx] = 0;
               owned_q[idx] = 0;
               refd_q[idx] = 0;
               accd_q[idx] = 0;
               exec_q[idx] = 0;
               level_q[idx] = 0;
               link_q[idx] = head_q;
               head_q = idx;
            end
         end
         KIND_MAP: begin
            owned_q[idx] = 1;
            level_q[idx] = r.owner_level;
            exec_q[idx] = r.executable;
            accd_q[idx] = 0;
         end
         default: accd_q[idx] = 1;
      endcase
      return mk(ST_DONE, 0, 0);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("Mismatch in %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   function automatic request_t mkreq(kind_type k, int f, int l, bit e);
      request_t r;
      r.kind = k;
      r.frame_index = f[5:0];
      r.owner_level = l[7:0];
      r.executable = e;
      return r;
   endfunction

   // Driver: bursts of random length with random gaps.
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_tready) begin
      end else begin
         if (req_tvalid) begin
            expected_responses.push_back(predict_response(request_t'(req_tdata[16:0])));
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            req_tdata <= {7'd0, pending_requests.pop_front()};
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern plus a long hold-off.
   int stall_phase = 0, hold_count = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_phase <= (stall_phase + 1) % 23;
         if (hold_off && hold_count < 400) begin
            hold_count <= hold_count + 1;
            rsp_tready <= 1'b0;
         end else if (stall_phase < 8) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      response_t got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = response_t'(rsp_tdata[14:0]);
            if (expected_responses.size() == 0) begin
               report_mismatch("unexpected response", 1, 0);
            end else begin
               want = expected_responses.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.granted_frame != want.granted_frame)
                  report_mismatch("granted_frame", got.granted_frame, want.granted_frame);
               if (got.swap_slot != want.swap_slot)
                  report_mismatch("swap_slot", got.swap_slot, want.swap_slot);
            end
         end
      end
   end

   initial begin
      int k, owned_span;
      for (int i = 0; i < FRAMES; i++) begin
         used_q[i] = 0; owned_q[i] = 0; refd_q[i] = 0; accd_q[i] = 0;
         exec_q[i] = 0; level_q[i] = 0; link_q[i] = i + 1;
      end
      head_q = 0; hand_q = 0; swap_q = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      pending_requests.push_back(mkreq(KIND_FREE, 5, 0, 0));
      pending_requests.push_back(mkreq(KIND_ALLOC, 0, 0, 0));
      pending_requests.push_back(mkreq(KIND_MAP, 0, 255, 1));
      pending_requests.push_back(mkreq(KIND_TOUCH, 63, 0, 0));
      pending_requests.push_back(mkreq(KIND_MAP, 63, 0, 0));
      pending_requests.push_back(mkreq(KIND_FREE, 0, 0, 0));
      pending_requests.push_back(mkreq(KIND_ALLOC, 63, 255, 1));
      for (int i = 0; i < 64; i++)
         pending_requests.push_back(mkreq(KIND_ALLOC, 0, 0, 0));
      pending_requests.push_back(mkreq(KIND_ALLOC, 0, 0, 0));
      pending_requests.push_back(mkreq(KIND_MAP, 10, 7, 0));
      pending_requests.push_back(mkreq(KIND_MAP, 20, 7, 0));
      pending_requests.push_back(mkreq(KIND_MAP, 30, 200, 1));
      pending_requests.push_back(mkreq(KIND_ALLOC, 0, 0, 0));
      pending_requests.push_back(mkreq(KIND_ALLOC, 0, 0, 0));
      pending_requests.push_back(mkreq(KIND_TOUCH, 20, 0, 0));

      // Long receiver hold-off while the sender keeps offering.
      wait (pending_requests.size() == 0);
      hold_off = 1;
      for (int i = 0; i < 20; i++)
         pending_requests.push_back(mkreq(KIND_TOUCH, $urandom_range(0, 63), 0, 0));

      // Random part: mostly map/touch/alloc/free over a window of owned frames.
      for (int i = 0; i < 550; i++) begin
         owned_span = $urandom_range(0, 9) == 0 ? 63 : 15;
         k = $urandom_range(0, 9);
         if (k < 3)
            pending_requests.push_back(mkreq(KIND_ALLOC, $urandom_range(0, 63),
                                             $urandom_range(0, 255), $urandom_range(0, 1)));
         else if (k < 6)
            pending_requests.push_back(mkreq(KIND_MAP, $urandom_range(0, owned_span),
                                             $urandom_range(0, 255),
                                             $urandom_range(0, 3) == 0));
         else if (k < 8)
            pending_requests.push_back(mkreq(KIND_TOUCH, $urandom_range(0, owned_span),
                                             $urandom_range(0, 255), $urandom_range(0, 1)));
         else
            pending_requests.push_back(mkreq(KIND_FREE, $urandom_range(0, owned_span),
                                             $urandom_range(0, 255), $urandom_range(0, 1)));
      end
      stimulus_done = 1;
      wait (pending_requests.size() == 0 && !req_tvalid && expected_responses.size() == 0);
      repeat (250) @(posedge clock);
      if (errors == 0 && expected_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### files.f
design/pfa_pkg.sv
design/page_frame_allocator_clock_evict_unit.sv
design/pfa_checker.sv
bench/page_frame_allocator_clock_evict_unit_tb.sv
